// ===== rtl/b64d_pkg.sv =====
// Package with the shared types and constants of the base64 decoder.
package b64d_pkg;

    localparam int QueueDepth = 2;
    localparam int QueuePtrWidth = $clog2(QueueDepth);
    localparam int QueueCountWidth = $clog2(QueueDepth + 1);

    typedef enum logic [1:0] {
        STATUS_DATA    = 2'd0,
        STATUS_END     = 2'd1,
        STATUS_INVALID = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CLASS_SPACE,
        CLASS_PAD,
        CLASS_SEXTET,
        CLASS_INVALID
    } char_class_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_message;
    } char_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        status_t    status;
        logic       message_done;
    } result_item_t;

    typedef struct packed {
        char_class_t char_class;
        logic [5:0]  sextet;
        logic        last;
    } queue_entry_t;

    typedef struct packed {
        logic         valid;
        queue_entry_t entry;
    } queue_head_t;

endpackage

// ===== rtl/base64_decoder_top.sv =====
// Top level of the streaming base64 decoder.
// A character's result passes through the queue register and then the output register before it appears.
// Throughput: one character per cycle, sustained while the result side does not stall.
// The two-entry queue holds up to two characters while a result waits to be taken.
// Reset clears the accumulator, the pad and error flags, the queue and the output valid flag.
module base64_decoder_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   char_valid,
    output logic                   char_stall,
    input  b64d_pkg::char_item_t   char_item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output b64d_pkg::result_item_t result_item
);

    logic                   queue_full;
    logic                   push;
    logic                   pop;
    b64d_pkg::queue_entry_t push_entry;
    b64d_pkg::queue_head_t  head;

    b64d_front u_front (
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    b64d_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head       (head)
    );

    b64d_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule

// ===== rtl/b64d_front.sv =====
// Front end: accepts characters, classifies them and pushes them into the queue.
module b64d_front (
    input  logic                   char_valid,
    output logic                   char_stall,
    input  b64d_pkg::char_item_t   char_item,
    input  logic                   queue_full,
    output logic                   push,
    output b64d_pkg::queue_entry_t push_entry
);

    logic [7:0] c;

    assign c = char_item.char_code;
    assign char_stall = queue_full;
    assign push = char_valid && !queue_full;

    always_comb
    begin
        push_entry.last = char_item.end_of_message;
        push_entry.sextet = 6'd0;
        push_entry.char_class = b64d_pkg::CLASS_INVALID;
        if ((c >= 8'd9 && c <= 8'd13) || c == 8'd32)
        begin
            push_entry.char_class = b64d_pkg::CLASS_SPACE;
        end
        else if (c == 8'd61)
        begin
            push_entry.char_class = b64d_pkg::CLASS_PAD;
        end
        else if (c >= 8'd65 && c <= 8'd90)
        begin
            push_entry.char_class = b64d_pkg::CLASS_SEXTET;
            push_entry.sextet = 6'(c - 8'd65);
        end
        else if (c >= 8'd97 && c <= 8'd122)
        begin
            push_entry.char_class = b64d_pkg::CLASS_SEXTET;
            push_entry.sextet = 6'(c - 8'd71);
        end
        else if (c >= 8'd48 && c <= 8'd57)
        begin
            push_entry.char_class = b64d_pkg::CLASS_SEXTET;
            push_entry.sextet = 6'(c + 8'd4);
        end
        else if (c == 8'd43)
        begin
            push_entry.char_class = b64d_pkg::CLASS_SEXTET;
            push_entry.sextet = 6'd62;
        end
        else if (c == 8'd47)
        begin
            push_entry.char_class = b64d_pkg::CLASS_SEXTET;
            push_entry.sextet = 6'd63;
        end
    end

endmodule

// ===== rtl/b64d_queue.sv =====
// Short queue of classified characters between the front end and the back end.
module b64d_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  b64d_pkg::queue_entry_t push_entry,
    output logic                   full,
    input  logic                   pop,
    output b64d_pkg::queue_head_t  head
);

    b64d_pkg::queue_entry_t entry_reg [b64d_pkg::QueueDepth];
    logic [b64d_pkg::QueuePtrWidth-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [b64d_pkg::QueuePtrWidth-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [b64d_pkg::QueueCountWidth-1:0] count_reg, count_next;

    assign full = (count_reg == b64d_pkg::QueueCountWidth'(b64d_pkg::QueueDepth));
    assign head.valid = (count_reg != '0);
    assign head.entry = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == b64d_pkg::QueuePtrWidth'(b64d_pkg::QueueDepth - 1))
                ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == b64d_pkg::QueuePtrWidth'(b64d_pkg::QueueDepth - 1))
                ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/b64d_back.sv =====
// Back end: runs the bit accumulator and holds the result in an output register.
module b64d_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  b64d_pkg::queue_head_t   head,
    output logic                    pop,
    output logic                    result_valid,
    input  logic                    result_stall,
    output b64d_pkg::result_item_t  result_item
);

    logic [11:0] acc_reg, acc_next;
    logic [3:0]  pending_reg, pending_next;
    logic        pad_reg, pad_next;
    logic        err_reg, err_next;
    logic        out_valid_reg, out_valid_next;
    b64d_pkg::result_item_t out_reg, out_next;

    logic [11:0] acc_shift;
    logic [3:0]  pending_sum;
    logic [7:0]  byte_sel;
    logic        have;

    assign pop = head.valid && (!out_valid_reg || !result_stall);
    assign result_valid = out_valid_reg;
    assign result_item = out_reg;
    assign acc_shift = {acc_reg[5:0], head.entry.sextet};
    assign pending_sum = pending_reg + 4'd6;

    always_comb
    begin
        unique case (pending_sum)
            4'd10:   byte_sel = acc_shift[9:2];
            4'd12:   byte_sel = acc_shift[11:4];
            default: byte_sel = acc_shift[7:0];
        endcase
    end

    always_comb
    begin
        acc_next = acc_reg;
        pending_next = pending_reg;
        pad_next = pad_reg;
        err_next = err_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        have = 1'b0;
        if (pop)
        begin
            out_next.data_byte = 8'd0;
            out_next.status = b64d_pkg::STATUS_END;
            out_next.message_done = head.entry.last;
            if (!pad_reg && !err_reg)
            begin
                unique case (head.entry.char_class)
                    b64d_pkg::CLASS_SPACE:
                    begin
                    end
                    b64d_pkg::CLASS_PAD:
                    begin
                        pad_next = 1'b1;
                    end
                    b64d_pkg::CLASS_INVALID:
                    begin
                        err_next = 1'b1;
                        have = 1'b1;
                        out_next.status = b64d_pkg::STATUS_INVALID;
                    end
                    b64d_pkg::CLASS_SEXTET:
                    begin
                        acc_next = acc_shift;
                        pending_next = pending_sum;
                        if (pending_sum >= 4'd8)
                        begin
                            pending_next = pending_sum - 4'd8;
                            have = 1'b1;
                            out_next.status = b64d_pkg::STATUS_DATA;
                            out_next.data_byte = byte_sel;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (head.entry.last)
            begin
                acc_next = 12'd0;
                pending_next = 4'd0;
                pad_next = 1'b0;
                err_next = 1'b0;
                have = 1'b1;
            end
            out_valid_next = have;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            pending_reg <= '0;
            pad_reg <= 1'b0;
            err_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            pending_reg <= pending_next;
            pad_reg <= pad_next;
            err_reg <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the streaming base64 decoder with directed and random messages.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_TYPED,
        ROW_SILENT
    } row_kind_t;

    typedef struct packed {
        b64d_pkg::char_item_t   item;
        row_kind_t              kind;
        b64d_pkg::result_item_t typed;
    } directed_row_t;

    localparam int StallLimit = 4000;
    localparam int DrainCycles = 10;
    localparam int LongHold = 60;
    localparam int PhaseChars = 350;

    localparam b64d_pkg::result_item_t END_MARK = '{8'h00, b64d_pkg::STATUS_END, 1'b1};
    localparam b64d_pkg::result_item_t NO_RESULT = '{8'h00, b64d_pkg::STATUS_DATA, 1'b0};
    localparam b64d_pkg::result_item_t BAD_CHAR = '{8'h00, b64d_pkg::STATUS_INVALID, 1'b0};
    localparam b64d_pkg::result_item_t BAD_LAST = '{8'h00, b64d_pkg::STATUS_INVALID, 1'b1};
    localparam b64d_pkg::result_item_t ALL_ONES_LAST = '{8'hFF, b64d_pkg::STATUS_DATA, 1'b1};

    localparam directed_row_t DirectedRows [25] = '{
        '{'{"A", 1'b1}, ROW_TYPED, END_MARK},
        '{'{8'd9, 1'b0}, ROW_PREDICT, NO_RESULT},
        '{'{"T", 1'b0}, ROW_PREDICT, NO_RESULT},
        '{'{"W", 1'b0}, ROW_PREDICT, NO_RESULT},
        '{'{"F", 1'b0}, ROW_PREDICT, NO_RESULT},
        '{'{"u", 1'b0}, ROW_PREDICT, NO_RESULT},
        '{'{8'd32, 1'b1}, ROW_TYPED, END_MARK},
        '{'{8'h00, 1'b0}, ROW_TYPED, BAD_CHAR},
        '{'{8'hFF, 1'b0}, ROW_SILENT, NO_RESULT},
        '{'{"A", 1'b1}, ROW_TYPED, END_MARK},
        '{'{8'hFF, 1'b1}, ROW_TYPED, BAD_LAST},
        '{'{"/", 1'b0}, ROW_PREDICT, NO_RESULT},
        '{'{"/", 1'b1}, ROW_TYPED, ALL_ONES_LAST},
        '{'{"+", 1'b0}, ROW_PREDICT, NO_RESULT},
        '{'{"+", 1'b0}, ROW_PREDICT, NO_RESULT},
        '{'{"z", 1'b0}, ROW_PREDICT, NO_RESULT},
        '{'{"9", 1'b1}, ROW_PREDICT, NO_RESULT},
        '{'{"Q", 1'b0}, ROW_PREDICT, NO_RESULT},
        '{'{"=", 1'b0}, ROW_PREDICT, NO_RESULT},
        '{'{"A", 1'b0}, ROW_PREDICT, NO_RESULT},
        '{'{"!", 1'b1}, ROW_TYPED, END_MARK},
        '{'{8'd10, 1'b0}, ROW_PREDICT, NO_RESULT},
        '{'{8'd13, 1'b0}, ROW_PREDICT, NO_RESULT},
        '{'{8'h80, 1'b0}, ROW_TYPED, BAD_CHAR},
        '{'{"=", 1'b1}, ROW_TYPED, END_MARK}
    };

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   char_valid;
    logic                   char_stall;
    b64d_pkg::char_item_t   char_item;
    logic                   result_valid;
    logic                   result_stall;
    b64d_pkg::result_item_t result_item;

    logic [11:0] acc_bits;
    logic [3:0]  pend_bits;
    logic        pad_flag;
    logic        err_flag;

    b64d_pkg::result_item_t pending_results[$];
    b64d_pkg::char_item_t   char_stream[$];
    int           send_idle_pct = 0;
    int           stall_pct = 0;
    bit           hold_request = 1'b0;
    int           mismatches = 0;
    int           chars_sent = 0;
    int           results_checked = 0;
    int           messages_sent = 0;

    base64_decoder_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .char_item   (char_item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_item (result_item)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit is_space(input logic [7:0] c);
        return (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
    endfunction

    function automatic logic [6:0] sextet_value(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return 7'(c - "A");
        if (c >= "a" && c <= "z") return 7'(c - "a" + 26);
        if (c >= "0" && c <= "9") return 7'(c - "0" + 52);
        if (c == "+") return 7'd62;
        if (c == "/") return 7'd63;
        return 7'd64;
    endfunction

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        if (v < 62) return 8'("0" + v - 52);
        if (v == 62) return "+";
        return "/";
    endfunction

    function automatic logic [7:0] space_char();
        int w;
        w = $urandom_range(9, 14);
        return (w == 14) ? 8'd32 : 8'(w);
    endfunction

    function automatic logic [7:0] invalid_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (sextet_value(c) != 7'd64 || is_space(c) || c == "=");
        return c;
    endfunction

    function automatic void clear_decoder();
        acc_bits = '0;
        pend_bits = '0;
        pad_flag = 1'b0;
        err_flag = 1'b0;
    endfunction

    function automatic void decode_char(input b64d_pkg::char_item_t item, output bit produced,
                                        output b64d_pkg::result_item_t res);
        logic [6:0] v;
        produced = 1'b0;
        res.data_byte = 8'h00;
        res.status = b64d_pkg::STATUS_END;
        res.message_done = item.end_of_message;
        if (!pad_flag && !err_flag && !is_space(item.char_code))
        begin
            if (item.char_code == "=")
            begin
                pad_flag = 1'b1;
            end
            else
            begin
                v = sextet_value(item.char_code);
                if (v[6])
                begin
                    err_flag = 1'b1;
                    produced = 1'b1;
                    res.status = b64d_pkg::STATUS_INVALID;
                end
                else
                begin
                    acc_bits = {acc_bits[5:0], v[5:0]};
                    pend_bits = pend_bits + 4'd6;
                    if (pend_bits >= 4'd8)
                    begin
                        res.data_byte = 8'(acc_bits >> (pend_bits - 4'd8));
                        pend_bits = pend_bits - 4'd8;
                        produced = 1'b1;
                        res.status = b64d_pkg::STATUS_DATA;
                    end
                end
            end
        end
        if (item.end_of_message)
        begin
            clear_decoder();
            produced = 1'b1;
        end
    endfunction

    task automatic send_char(input b64d_pkg::char_item_t item, input row_kind_t kind,
                             input b64d_pkg::result_item_t typed);
        bit                     produced;
        b64d_pkg::result_item_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_item <= item;
        do
            @(posedge clk);
        while (char_stall);
        chars_sent++;
        decode_char(item, produced, predicted);
        case (kind)
            ROW_TYPED: pending_results.insert(pending_results.size(), typed);
            ROW_PREDICT: if (produced) pending_results.insert(pending_results.size(), predicted);
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        char_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic append_message();
        b64d_pkg::char_item_t msg[$];
        int         kind;
        int         groups;
        int         tail;
        int         count;
        kind = $urandom_range(99);
        if (kind >= 85)
        begin
            count = $urandom_range(1, 12);
            repeat (count)
                msg.insert(msg.size(),
                           b64d_pkg::char_item_t'{8'($urandom_range(255)), 1'b0});
        end
        else
        begin
            groups = $urandom_range(0, 3);
            tail = $urandom_range(0, 2);
            count = 4 * groups + ((tail == 0) ? 0 : tail + 1);
            for (int i = 0; i < count; i++)
            begin
                if ($urandom_range(9) == 0)
                    msg.insert(msg.size(), b64d_pkg::char_item_t'{space_char(), 1'b0});
                msg.insert(msg.size(),
                           b64d_pkg::char_item_t'{sextet_char(6'($urandom_range(63))), 1'b0});
            end
            if (tail != 0)
                repeat (3 - tail) msg.insert(msg.size(), b64d_pkg::char_item_t'{"=", 1'b0});
            if ($urandom_range(3) == 0)
                msg.insert(msg.size(),
                           b64d_pkg::char_item_t'{sextet_char(6'($urandom_range(63))), 1'b0});
            if (kind >= 70)
                msg.insert($urandom_range(msg.size()),
                           b64d_pkg::char_item_t'{invalid_char(), 1'b0});
        end
        if (msg.size() == 0) msg.insert(0, b64d_pkg::char_item_t'{space_char(), 1'b0});
        msg[msg.size() - 1].end_of_message = 1'b1;
        char_stream = {char_stream, msg};
        messages_sent++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            results_checked++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction: %p", result_item);
                mismatches++;
            end
            else
            begin
                automatic b64d_pkg::result_item_t want = pending_results.pop_front();
                if (result_item.data_byte !== want.data_byte)
                begin
                    $error("data_byte: expected %0h, actual %0h", want.data_byte,
                           result_item.data_byte);
                    mismatches++;
                end
                if (result_item.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, result_item.status);
                    mismatches++;
                end
                if (result_item.message_done !== want.message_done)
                begin
                    $error("message_done: expected %0b, actual %0b", want.message_done,
                           result_item.message_done);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = LongHold;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < StallLimit)
        begin
            @(posedge clk);
            if ((char_valid && !char_stall) || (result_valid && !result_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("[base64_decoder_top] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        rst_n = 1'b0;
        char_valid = 1'b0;
        char_item = '0;
        clear_decoder();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DirectedRows[i])
            send_char(DirectedRows[i].item, DirectedRows[i].kind, DirectedRows[i].typed);
        wait_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0; stall_pct = 0; end
                1: begin send_idle_pct = 67; stall_pct = 0; end
                2: begin send_idle_pct = 0; stall_pct = 67; end
                default: begin send_idle_pct = 35; stall_pct = 35; end
            endcase
            char_stream.delete();
            while (char_stream.size() < PhaseChars) append_message();
            if (phase == 0) hold_request = 1'b1;
            foreach (char_stream[i]) send_char(char_stream[i], ROW_PREDICT, NO_RESULT);
            wait_drained();
        end

        repeat (DrainCycles) @(posedge clk);
        $display("Covered %0d characters in %0d random messages plus the directed table,",
                 chars_sent, messages_sent);
        $display("with %0d result transactions checked over four flow-control phases.",
                 results_checked);
        if (mismatches == 0)
            $display("[base64_decoder_top] OK");
        else
            $display("[base64_decoder_top] ERROR");
        $finish;
    end

endmodule
